### design/vta_pkg.sv
// Package: widths, constants, types and the arctangent table of the angle block.
`timescale 1ns / 1ps
package vta_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int TABLE_LEN    = 24;
    localparam int CORDIC_N     = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
    localparam int STEP_W       = $clog2(CORDIC_N);
    localparam int CNT_W        = $clog2(CORDIC_N + 2);

    localparam int REG_W     = 16;   // Q1.14 registers and vector components
    localparam int CFG_IDX_W = 3;
    localparam int T_W       = 33;   // cross product component
    localparam int D_W       = 34;   // a and p dot products
    localparam int TD_W      = 50;   // t dot product
    localparam int CW        = 52;   // rotator x / y
    localparam int ZW        = 26;   // angle accumulator, 1/65536 degree
    localparam int RAW_W     = 17;   // rounded angle, 1/128 degree
    localparam int ANG_W     = 21;   // output angle
    localparam int UW        = ANG_W + 1;

    localparam int HALF_TURN        = 23040;
    localparam int QUARTER_TURN     = 11520;
    localparam int ACC_HALF_TURN    = 11796480;
    localparam int OUT_MAX          = 1048575;
    localparam int OUT_MIN          = -1048576;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DOT,
        S_RUN,
        S_FIN,
        S_DONE
    } t_state;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AXIS_X = 3'd0,
        CFG_AXIS_Y = 3'd1,
        CFG_AXIS_Z = 3'd2,
        CFG_PERP_X = 3'd3,
        CFG_PERP_Y = 3'd4,
        CFG_PERP_Z = 3'd5
    } t_cfg_idx;

    // rotator state handed from cell to cell
    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
    } t_cord;

    // atan(2^-i) in 1/65536 degree
    function automatic logic signed [ZW-1:0] atan_lut(input logic [4:0] i);
        logic signed [ZW-1:0] v;
        unique case (i)
            5'd0:  v = ZW'(2949120);
            5'd1:  v = ZW'(1740967);
            5'd2:  v = ZW'(919879);
            5'd3:  v = ZW'(466945);
            5'd4:  v = ZW'(234379);
            5'd5:  v = ZW'(117304);
            5'd6:  v = ZW'(58666);
            5'd7:  v = ZW'(29335);
            5'd8:  v = ZW'(14668);
            5'd9:  v = ZW'(7334);
            5'd10: v = ZW'(3667);
            5'd11: v = ZW'(1833);
            5'd12: v = ZW'(917);
            5'd13: v = ZW'(458);
            5'd14: v = ZW'(229);
            5'd15: v = ZW'(115);
            5'd16: v = ZW'(57);
            5'd17: v = ZW'(29);
            5'd18: v = ZW'(14);
            5'd19: v = ZW'(7);
            5'd20: v = ZW'(4);
            5'd21: v = ZW'(2);
            5'd22: v = ZW'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

### design/vta_if.sv
// Interfaces: request channel (vector) and result channel (angles).
`timescale 1ns / 1ps
interface vta_req_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [vta_pkg::REG_W-1:0]     vec_x;
    logic signed [vta_pkg::REG_W-1:0]     vec_y;
    logic signed [vta_pkg::REG_W-1:0]     vec_z;
    logic                                 restart;
    modport source (output valid, vec_x, vec_y, vec_z, restart, input ready);
    modport sink   (input valid, vec_x, vec_y, vec_z, restart, output ready);
endinterface

interface vta_res_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [vta_pkg::ANG_W-1:0]     theta_angle;
    logic signed [vta_pkg::ANG_W-1:0]     phi_angle;
    logic                                 saturated;
    modport source (output valid, theta_angle, phi_angle, saturated, input ready);
    modport sink   (input valid, theta_angle, phi_angle, saturated, output ready);
endinterface

### design/vector_to_unwrapped_angles.sv
// Top level: vector to theta / phi angles with unwrapping against the previous sample.
`timescale 1ns / 1ps
// Usage:
//  - i_req carries one vector (vec_x, vec_y, vec_z, Q1.14) and a restart flag per
//    request; o_res returns one result (theta_angle, phi_angle in 1/128 degree,
//    saturated) per request, in order.
//  - Frame registers are written over i_cfg_we / i_cfg_idx / i_cfg_data while
//    the block is idle: 0..2 axis x/y/z, 3..5 perpendicular x/y/z.
//  - From request to result valid: dot products are summed component by
//    component on the multiply-accumulate lanes, then theta and phi enter the
//    row of CORDIC_N rotator cells on consecutive cycles, then S_FIN unwraps
//    and clips and S_DONE loads the result register.
//  - A new request is taken only in S_IDLE, once the previous result is loaded;
//    the row of rotator cells holds only one request's two angles at a time.
//  - The result register lets a new request in while a result waits; if the
//    receiver still stalls when the next result is done, that result holds
//    and no further request is taken until the register frees.
//  - Reset (i_rst_n low, synchronous) restores the default frame (axis +z,
//    perpendicular +x), clears the previous angles and drops o_res.valid.
module vector_to_unwrapped_angles (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    vta_req_if.sink                          i_req,
    vta_res_if.source                        o_res,
    input  logic                             i_cfg_we,
    input  logic [vta_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [vta_pkg::REG_W-1:0]        i_cfg_data
);
    import vta_pkg::*;

    // frame registers
    logic signed [REG_W-1:0] r_ax, r_ay, r_az, r_px, r_py, r_pz;
    // third frame vector
    logic signed [T_W-1:0]   r_tx, r_ty, r_tz;
    // request
    logic signed [REG_W-1:0] r_vx, r_vy, r_vz;
    logic                    r_restart;
    // dot products
    logic signed [D_W-1:0]   r_a, r_p;
    logic signed [TD_W-1:0]  r_t;
    // control
    t_state                  r_state, n_state;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    // special cases and raw angles
    logic                    r_sp_th, r_sp_ph;
    logic signed [RAW_W-1:0] r_spv_th, r_spv_ph, r_raw_th, r_raw_ph;
    // previous angles and pending result
    logic signed [ANG_W-1:0] r_last_th, r_last_ph, r_res_th, r_res_ph;
    logic                    r_res_sat;
    // result register
    logic                    r_out_valid;
    logic signed [ANG_W-1:0] r_out_th, r_out_ph;
    logic                    r_out_sat;

    logic w_accept, w_load, w_free;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ax <= '0;
            r_ay <= '0;
            r_az <= REG_W'(16384);
            r_px <= REG_W'(16384);
            r_py <= '0;
            r_pz <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_AXIS_X: r_ax <= i_cfg_data;
                CFG_AXIS_Y: r_ay <= i_cfg_data;
                CFG_AXIS_Z: r_az <= i_cfg_data;
                CFG_PERP_X: r_px <= i_cfg_data;
                CFG_PERP_Y: r_py <= i_cfg_data;
                CFG_PERP_Z: r_pz <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // cross product A x P, exact
    always_ff @(posedge i_clk) begin
        r_tx <= T_W'(r_ay) * T_W'(r_pz) - T_W'(r_az) * T_W'(r_py);
        r_ty <= T_W'(r_az) * T_W'(r_px) - T_W'(r_ax) * T_W'(r_pz);
        r_tz <= T_W'(r_ax) * T_W'(r_py) - T_W'(r_ay) * T_W'(r_px);
    end

    // dot product lanes: one component per cycle
    logic signed [REG_W-1:0]  w_v, w_ac, w_pc;
    logic signed [T_W-1:0]    w_tc;
    logic signed [2*REG_W-1:0] w_pa, w_pp;
    logic signed [TD_W-1:0]   w_pt;

    always_comb begin
        unique case (r_cnt[1:0])
            2'd0: begin
                w_v = r_vx; w_ac = r_ax; w_pc = r_px; w_tc = r_tx;
            end
            2'd1: begin
                w_v = r_vy; w_ac = r_ay; w_pc = r_py; w_tc = r_ty;
            end
            default: begin
                w_v = r_vz; w_ac = r_az; w_pc = r_pz; w_tc = r_tz;
            end
        endcase
    end

    assign w_pa = w_ac * w_v;
    assign w_pp = w_pc * w_v;
    assign w_pt = TD_W'(w_tc) * TD_W'(w_v);

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_vx      <= i_req.vec_x;
            r_vy      <= i_req.vec_y;
            r_vz      <= i_req.vec_z;
            r_restart <= i_req.restart;
        end
        if (r_state == S_DOT) begin
            if (r_cnt == '0) begin
                r_a <= D_W'(w_pa);
                r_p <= D_W'(w_pp);
                r_t <= w_pt;
            end else begin
                r_a <= r_a + D_W'(w_pa);
                r_p <= r_p + D_W'(w_pp);
                r_t <= r_t + w_pt;
            end
        end
    end

    // operand select and pre-rotation: theta at count 0, phi at count 1
    logic signed [CW-1:0]    w_t_ext, w_a_ext, w_p_ext, w_y, w_x;
    logic                    w_sp;
    logic signed [RAW_W-1:0] w_spv;
    t_cord                   w_in, w_out;

    assign w_t_ext = CW'(r_t);
    assign w_a_ext = CW'(r_a) <<< 14;
    assign w_p_ext = CW'(r_p) <<< 14;
    assign w_y     = r_cnt[0] ? w_a_ext : w_t_ext;
    assign w_x     = r_cnt[0] ? w_t_ext : w_p_ext;

    always_comb begin
        w_sp  = (w_y == '0) || (w_x == '0);
        if (w_y == '0) begin
            w_spv = (w_x < 0) ? RAW_W'(HALF_TURN) : '0;
        end else begin
            w_spv = (w_y > 0) ? RAW_W'(QUARTER_TURN) : -RAW_W'(QUARTER_TURN);
        end
        if (w_x < 0) begin
            w_in.x = -w_x;
            w_in.y = -w_y;
            w_in.z = (w_y >= 0) ? ZW'(ACC_HALF_TURN) : -ZW'(ACC_HALF_TURN);
        end else begin
            w_in.x = w_x;
            w_in.y = w_y;
            w_in.z = '0;
        end
    end

    vta_chain u_chain (
        .i_clk (i_clk),
        .i_d   (w_in),
        .o_d   (w_out)
    );

    // round half up to 1/128 degree
    logic signed [ZW-1:0]    w_zr;
    logic signed [RAW_W-1:0] w_round;
    assign w_zr    = w_out.z + ZW'(256);
    assign w_round = RAW_W'(w_zr >>> 9);

    always_ff @(posedge i_clk) begin
        if (r_state == S_RUN) begin
            if (r_cnt == CNT_W'(0)) begin
                r_sp_th  <= w_sp;
                r_spv_th <= w_spv;
            end
            if (r_cnt == CNT_W'(1)) begin
                r_sp_ph  <= w_sp;
                r_spv_ph <= w_spv;
            end
            if (r_cnt == CNT_W'(CORDIC_N)) begin
                r_raw_th <= r_sp_th ? r_spv_th : w_round;
            end
            if (r_cnt == CNT_W'(CORDIC_N + 1)) begin
                r_raw_ph <= r_sp_ph ? r_spv_ph : w_round;
            end
        end
    end

    // unwrap by one half turn toward the previous angle
    function automatic logic signed [UW-1:0] unwrap(input logic signed [RAW_W-1:0] ang,
                                                    input logic signed [ANG_W-1:0] prev);
        logic signed [UW-1:0] d;
        logic signed [UW-1:0] a;
        a = UW'(ang);
        d = a - UW'(prev);
        if (d > UW'(QUARTER_TURN)) begin
            a = a - UW'(HALF_TURN);
        end else if (d < -UW'(QUARTER_TURN)) begin
            a = a + UW'(HALF_TURN);
        end
        return a;
    endfunction

    logic signed [ANG_W-1:0] w_pth, w_pph, w_th, w_ph;
    logic signed [UW-1:0]    w_uth, w_uph;
    logic                    w_sat_th, w_sat_ph;

    assign w_pth = r_restart ? '0 : r_last_th;
    assign w_pph = r_restart ? '0 : r_last_ph;
    assign w_uth = unwrap(r_raw_th, w_pth);
    assign w_uph = unwrap(r_raw_ph, w_pph);

    // clip to the output range
    always_comb begin
        w_sat_th = 1'b0;
        w_sat_ph = 1'b0;
        w_th     = ANG_W'(w_uth);
        w_ph     = ANG_W'(w_uph);
        if (w_uth > UW'(OUT_MAX)) begin
            w_th = ANG_W'(OUT_MAX); w_sat_th = 1'b1;
        end else if (w_uth < UW'(OUT_MIN)) begin
            w_th = ANG_W'(OUT_MIN); w_sat_th = 1'b1;
        end
        if (w_uph > UW'(OUT_MAX)) begin
            w_ph = ANG_W'(OUT_MAX); w_sat_ph = 1'b1;
        end else if (w_uph < UW'(OUT_MIN)) begin
            w_ph = ANG_W'(OUT_MIN); w_sat_ph = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_th <= '0;
            r_last_ph <= '0;
        end else if (r_state == S_FIN) begin
            r_last_th <= w_th;
            r_last_ph <= w_ph;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FIN) begin
            r_res_th  <= w_th;
            r_res_ph  <= w_ph;
            r_res_sat <= w_sat_th | w_sat_ph;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt + CNT_W'(1);
        unique case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (i_req.valid) begin
                    n_state = S_DOT;
                end
            end
            S_DOT: begin
                if (r_cnt == CNT_W'(2)) begin
                    n_state = S_RUN;
                    n_cnt   = '0;
                end
            end
            S_RUN: begin
                if (r_cnt == CNT_W'(CORDIC_N + 1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs of the controller
    always_comb begin
        i_req.ready = 1'b0;
        w_load      = 1'b0;
        unique case (r_state)
            S_IDLE:  i_req.ready = 1'b1;
            S_DONE:  w_load      = w_free;
            default: ;
        endcase
    end

    assign w_free   = !r_out_valid || o_res.ready;
    assign w_accept = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_th  <= r_res_th;
            r_out_ph  <= r_res_ph;
            r_out_sat <= r_res_sat;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.theta_angle = r_out_th;
    assign o_res.phi_angle   = r_out_ph;
    assign o_res.saturated   = r_out_sat;

endmodule

### design/vta_cell.sv
// One vectoring rotator step with a fixed shift given by its position in the row.
`timescale 1ns / 1ps
module vta_cell (
    input  logic                          i_clk,
    input  logic [vta_pkg::STEP_W-1:0]    i_idx,
    input  vta_pkg::t_cord                i_d,
    output vta_pkg::t_cord                o_d
);
    import vta_pkg::*;

    t_cord r_d;
    t_cord n_d;
    logic signed [CW-1:0] w_xs;
    logic signed [CW-1:0] w_ys;
    logic signed [ZW-1:0] w_ang;

    assign w_xs  = i_d.x >>> i_idx;
    assign w_ys  = i_d.y >>> i_idx;
    assign w_ang = atan_lut(5'(i_idx));

    // rotate toward the x axis
    always_comb begin
        if (i_d.y > 0) begin
            n_d.x = i_d.x + w_ys;
            n_d.y = i_d.y - w_xs;
            n_d.z = i_d.z + w_ang;
        end else begin
            n_d.x = i_d.x - w_ys;
            n_d.y = i_d.y + w_xs;
            n_d.z = i_d.z - w_ang;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d <= n_d;
    end

    assign o_d = r_d;

endmodule

### design/vta_chain.sv
// Row of rotator cells; data moves one cell per cycle.
`timescale 1ns / 1ps
module vta_chain (
    input  logic              i_clk,
    input  vta_pkg::t_cord    i_d,
    output vta_pkg::t_cord    o_d
);
    import vta_pkg::*;

    t_cord w_link [CORDIC_N+1];

    assign w_link[0] = i_d;

    for (genvar g = 0; g < CORDIC_N; g++) begin : g_cell
        vta_cell u_cell (
            .i_clk (i_clk),
            .i_idx (STEP_W'(g)),
            .i_d   (w_link[g]),
            .o_d   (w_link[g+1])
        );
    end

    assign o_d = w_link[CORDIC_N];

endmodule

### dv/testbench.sv
// Testbench for vector_to_unwrapped_angles: stimulus queue, driver, angle predictor, checker.
`timescale 1ns / 1ps
module testbench;
    import vta_pkg::*;

    typedef struct {
        logic signed [REG_W-1:0] vx, vy, vz;
        logic                    restart;
    } t_sample;

    typedef struct {
        logic signed [ANG_W-1:0] theta, phi;
        logic                    sat;
    } t_angles;

    // atan(2^-i) in 1/65536 degree
    localparam longint ATAN_STEP [24] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };
    localparam int STALL_LIMIT = 5000;

    logic i_clk, i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [REG_W-1:0]     i_cfg_data;

    vta_req_if req_ch ();
    vta_res_if res_ch ();

    vector_to_unwrapped_angles DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req(req_ch.sink), .o_res(res_ch.source),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    t_sample pending_samples[$];
    t_angles expected_angles[$];
    longint  frame_reg [6];
    longint  prev_theta, prev_phi;
    int      send_idle_pct, recv_idle_pct;
    int      error_count, sample_count, result_count, stall_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // atan2 in 1/128 degree, vectoring rotation
    function automatic longint atan2_deg128(longint y, longint x);
        longint z, xn, yn;
        z = 0;
        if (y == 0) return (x < 0) ? HALF_TURN : 0;
        if (x == 0) return (y > 0) ? QUARTER_TURN : -QUARTER_TURN;
        if (x < 0) begin
            z = (y >= 0) ? ACC_HALF_TURN : -ACC_HALF_TURN;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < CORDIC_N; i++) begin
            if (y > 0) begin
                xn = x + (y >>> i);
                yn = y - (x >>> i);
                z += ATAN_STEP[i];
            end else begin
                xn = x - (y >>> i);
                yn = y + (x >>> i);
                z -= ATAN_STEP[i];
            end
            x = xn;
            y = yn;
        end
        return (z + 256) >>> 9;
    endfunction

    function automatic longint unwrap_toward(longint ang, longint prev);
        if (ang - prev > QUARTER_TURN) return ang - HALF_TURN;
        if (ang - prev < -QUARTER_TURN) return ang + HALF_TURN;
        return ang;
    endfunction

    function automatic longint clip_angle(longint v, ref logic sat);
        if (v > OUT_MAX) begin sat = 1'b1; return OUT_MAX; end
        if (v < OUT_MIN) begin sat = 1'b1; return OUT_MIN; end
        return v;
    endfunction

    // project onto the frame, take both angles, unwrap, clip and update history
    function automatic t_angles predict_angles(t_sample s);
        longint ax, ay, az, px, py, pz, tx, ty, tz, a, p, t, th, ph, pth, pph;
        logic   sat;
        t_angles r;
        ax = frame_reg[CFG_AXIS_X]; ay = frame_reg[CFG_AXIS_Y]; az = frame_reg[CFG_AXIS_Z];
        px = frame_reg[CFG_PERP_X]; py = frame_reg[CFG_PERP_Y]; pz = frame_reg[CFG_PERP_Z];
        sat = 1'b0;
        tx = ay * pz - az * py;
        ty = az * px - ax * pz;
        tz = ax * py - ay * px;
        t = tx * s.vx + ty * s.vy + tz * s.vz;
        a = (ax * s.vx + ay * s.vy + az * s.vz) * 16384;
        p = (px * s.vx + py * s.vy + pz * s.vz) * 16384;
        pth = s.restart ? 0 : prev_theta;
        pph = s.restart ? 0 : prev_phi;
        th = clip_angle(unwrap_toward(atan2_deg128(t, p), pth), sat);
        ph = clip_angle(unwrap_toward(atan2_deg128(a, t), pph), sat);
        prev_theta = th;
        prev_phi = ph;
        r.theta = th[ANG_W-1:0];
        r.phi = ph[ANG_W-1:0];
        r.sat = sat;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        error_count++;
        $display("mismatch on result %0d: %s got %0d expected %0d",
                 result_count, what, got, want);
    endtask

    // driver: next request when the channel is free
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else if (!req_ch.valid || req_ch.ready) begin
            if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                t_sample s;
                s = pending_samples.pop_front();
                req_ch.valid   <= 1'b1;
                req_ch.vec_x   <= s.vx;
                req_ch.vec_y   <= s.vy;
                req_ch.vec_z   <= s.vz;
                req_ch.restart <= s.restart;
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // receiver back-pressure
    always @(posedge i_clk) begin
        res_ch.ready <= i_rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    // monitor: predict on accepted requests, check accepted results
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_ch.valid && req_ch.ready) begin
                t_sample s;
                s.vx = req_ch.vec_x; s.vy = req_ch.vec_y; s.vz = req_ch.vec_z;
                s.restart = req_ch.restart;
                expected_angles.push_back(predict_angles(s));
                sample_count++;
            end
            if (res_ch.valid && res_ch.ready) begin
                t_angles e;
                if (expected_angles.size() == 0) begin
                    error_count++;
                    $display("result with no request outstanding");
                end else begin
                    e = expected_angles.pop_front();
                    if (res_ch.theta_angle !== e.theta)
                        report_mismatch("theta", res_ch.theta_angle, e.theta);
                    if (res_ch.phi_angle !== e.phi)
                        report_mismatch("phi", res_ch.phi_angle, e.phi);
                    if (res_ch.saturated !== e.sat)
                        report_mismatch("saturated", res_ch.saturated, e.sat);
                end
                result_count++;
            end
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles > STALL_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic write_reg(t_cfg_idx idx, logic [REG_W-1:0] v);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= v;
        frame_reg[idx] = longint'($signed(v));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic add_sample(logic [REG_W-1:0] x, logic [REG_W-1:0] y,
                              logic [REG_W-1:0] z, logic rs);
        t_sample s;
        s.vx = x; s.vy = y; s.vz = z; s.restart = rs;
        pending_samples.push_back(s);
    endtask

    // wait until every request is out and every result back, then let the pipe drain
    task automatic drain();
        while (pending_samples.size() != 0 || req_ch.valid || expected_angles.size() != 0)
            @(posedge i_clk);
        repeat (CORDIC_N + 16) @(posedge i_clk);
    endtask

    task automatic add_random(int n);
        logic [REG_W-1:0] x, y, z;
        for (int i = 0; i < n; i++) begin
            x = REG_W'($urandom); y = REG_W'($urandom); z = REG_W'($urandom);
            // mostly slow-moving series so unwrapping sees its neighborhood
            if ($urandom_range(3) != 0 && pending_samples.size() != 0) begin
                x = REG_W'(pending_samples[$].vx + $signed(REG_W'($urandom_range(8191))) - 4096);
                y = REG_W'(pending_samples[$].vy + $signed(REG_W'($urandom_range(8191))) - 4096);
                z = REG_W'(pending_samples[$].vz + $signed(REG_W'($urandom_range(8191))) - 4096);
            end
            add_sample(x, y, z, $urandom_range(15) == 0);
        end
    endtask

    task automatic random_frame();
        for (int r = 0; r < 6; r++)
            write_reg(t_cfg_idx'(r), REG_W'($urandom_range(32768) - 16384));
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0; i_cfg_idx = '0; i_cfg_data = '0;
        req_ch.valid = 1'b0; req_ch.vec_x = '0; req_ch.vec_y = '0; req_ch.vec_z = '0;
        req_ch.restart = 1'b0;
        res_ch.ready = 1'b0;
        send_idle_pct = 0; recv_idle_pct = 0;
        error_count = 0; sample_count = 0; result_count = 0; stall_cycles = 0;
        prev_theta = 0; prev_phi = 0;
        frame_reg = '{0, 0, 16384, 16384, 0, 0};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: zero vector, axis cases, half-turn wrap, field extremes
        add_sample(0, 0, 0, 1);
        add_sample(-16'sd16384, 0, 0, 0);
        add_sample(0, 16384, 0, 0);
        add_sample(0, -16'sd16384, 0, 0);
        add_sample(-16'sd100, 5, 0, 0);
        add_sample(-16'sd100, -16'sd5, 0, 0);
        add_sample(-16'sd100, 5, 7, 0);
        add_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 0);
        add_sample(16'h8000, 16'h8000, 16'h8000, 0);
        add_sample(16'h7FFF, 16'h8000, 16'h7FFF, 0);
        add_sample(16'h8000, 16'h7FFF, 16'h8000, 1);
        add_sample(-16'sd16384, 1, 0, 0);
        add_sample(-16'sd16384, -16'sd1, 0, 0);
        add_sample(-16'sd16384, 1, 0, 0);
        add_sample(0, 0, -16'sd16384, 0);
        add_sample(0, 0, 16384, 0);
        add_sample(1, 1, 1, 0);
        add_sample(-16'sd1, -16'sd1, -16'sd1, 1);
        add_random(220);
        drain();

        // sender idles; frame entries at +1.0 and -1.0 (0x4000 / 0xC000)
        send_idle_pct = 47;
        write_reg(CFG_AXIS_X, 16'h4000); write_reg(CFG_AXIS_Y, 16'hC000);
        write_reg(CFG_AXIS_Z, 16'h4000); write_reg(CFG_PERP_X, 16'hC000);
        write_reg(CFG_PERP_Y, 16'h4000); write_reg(CFG_PERP_Z, 16'hC000);
        add_random(240);
        drain();

        // receiver stalls; axis x set to 0x7FFF and perpendicular y to 0x8000, then a random frame
        send_idle_pct = 0; recv_idle_pct = 47;
        write_reg(CFG_AXIS_X, 16'h7FFF); write_reg(CFG_PERP_Y, 16'h8000);
        random_frame();
        add_random(240);
        drain();

        // both sides idle; degenerate all-zero then random frame
        send_idle_pct = 29; recv_idle_pct = 29;
        for (int r = 0; r < 6; r++) write_reg(t_cfg_idx'(r), 16'h0000);
        add_random(10);
        drain();
        random_frame();
        add_random(230);
        drain();

        $display("covered %0d requests and %0d results over five frame settings",
                 sample_count, result_count);
        $display("with sender gaps, receiver stalls and both; %0d mismatches", error_count);
        if (error_count == 0 && expected_angles.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
